### hdl/brb_pkg.sv
`default_nettype none
package brb_pkg;

	localparam int CAPACITY = 1023;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int PTR_W    = $clog2(SLOTS);

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_READ = 2'd1,
		KIND_DROP = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic        drop_all;
		logic [9:0]  drop_count;
		logic [9:0]  read_offset;
		logic        overwrite_old;
		logic [15:0] burst_length;
		logic        burst_start;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [9:0] free_count;
		logic [9:0] fill_count;
		logic       read_valid;
		logic [7:0] read_data;
		logic       accepted;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // word other than a read hit accepted, result computed now
		logic rd_issue;  // read hit accepted, memory read started
		logic rd_load;   // memory data ready, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_hit;    // current input is a read inside the fill level
	} stat_t;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W+1)'(SLOTS))
			s = s - (PTR_W+1)'(SLOTS);
		return s[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] tail);
		logic [PTR_W:0] f;
		if (tail >= head)
			f = {1'b0, tail} - {1'b0, head};
		else
			f = (PTR_W+1)'(SLOTS) - {1'b0, head} + {1'b0, tail};
		return f[PTR_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hdl/byte_ring_buffer_unit.sv
// Byte ring buffer, 1023 bytes deep (1024 slots, one kept spare).
// Input stream: s_tvalid/s_tready, s_tuser = operation kind (0 push,
// 1 read at offset, 2 drop from front, 3 no operation), s_tdata = operands.
// Output stream: one word per input word, m_tvalid/m_tready, m_tdata holds
// accepted, read data/valid and the fill and free counts after the op.
// Push, drop and no-op words produce their result in the cycle after accept
// and a new word can be taken every cycle while the receiver keeps up. A read
// that falls inside the fill level goes through the single-port byte memory
// with a registered read, then the result register, and blocks the input.
// A read beyond the fill level is answered like any other word.
// The output word sits in a register; while the receiver stalls, the
// input takes a new word only in the cycle the held word is taken.
// Reset clears head, tail and burst status (buffer empty); memory
// contents are not cleared and need no clearing pass.
`default_nettype none
module byte_ring_buffer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [7:0] data_byte, [8] burst_start, [24:9] burst_length, [25] overwrite_old,
	// [35:26] read_offset, [45:36] drop_count, [46] drop_all, [47] zero
	input  wire logic [brb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  wire logic [1:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [0] accepted, [8:1] read_data, [9] read_valid, [19:10] fill_count,
	// [29:20] free_count, [31:30] zero
	output logic [brb_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	brb_pkg::item_t   item;
	brb_pkg::kind_t   kind;
	brb_pkg::cmd_t    cmd;
	brb_pkg::stat_t   stat;
	brb_pkg::result_t result;

	assign item = s_tdata[$bits(brb_pkg::item_t)-1:0];
	assign kind = brb_pkg::kind_t'(s_tuser);
	assign m_tdata = {(brb_pkg::OUT_TDATA_W - $bits(brb_pkg::result_t))'(0), result};

	brb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brb_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.kind   (kind),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule
`default_nettype wire

### hdl/brb_ctrl.sv
`default_nettype none
module brb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire brb_pkg::stat_t stat,
	output brb_pkg::cmd_t       cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.take     = accept && !stat.rd_hit;
		cmd.rd_issue = accept && stat.rd_hit;
		cmd.rd_load  = (state_q == ST_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// a read hit waits in ST_READ for the memory data
						m_tvalid_q <= !stat.rd_hit;
						if (stat.rd_hit)
							state_q <= ST_READ;
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_READ: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/brb_datapath.sv
`default_nettype none
module brb_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire brb_pkg::item_t   item,
	input  wire brb_pkg::kind_t   kind,
	input  wire brb_pkg::cmd_t    cmd,
	output brb_pkg::stat_t        stat,
	output brb_pkg::result_t      result
);

	logic [7:0]                mem [brb_pkg::SLOTS];
	logic [7:0]                mem_rd_q;
	logic [brb_pkg::PTR_W-1:0] head_q, tail_q;
	logic                      burst_rej_q;
	brb_pkg::result_t          result_q;

	logic [brb_pkg::PTR_W-1:0] fill, fill_push, fill_new;
	logic [brb_pkg::PTR_W-1:0] head_n, tail_n, rd_addr;
	logic                      rej, rej_n, push_acc, mem_we, acc;

	assign fill    = brb_pkg::fill_of(head_q, tail_q);
	assign rd_addr = brb_pkg::wrap_add(head_q, brb_pkg::PTR_W'(item.read_offset));

	always_comb begin
		stat.rd_hit = (kind == brb_pkg::KIND_READ) &&
			(brb_pkg::PTR_W'(item.read_offset) < fill);
	end

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		rej_n     = burst_rej_q;
		push_acc  = 1'b0;
		mem_we    = 1'b0;
		fill_push = fill;
		rej       = (item.burst_length == 16'd0) || (!item.overwrite_old &&
			(17'(item.burst_length) > 17'(brb_pkg::CAPACITY) - 17'(fill)));
		unique case (kind)
			brb_pkg::KIND_PUSH: begin
				if (item.burst_start)
					rej_n = rej;
				if (!rej_n) begin
					// overwrite: full buffer discards its oldest byte first
					if (fill >= brb_pkg::PTR_W'(brb_pkg::CAPACITY) && item.overwrite_old) begin
						head_n    = brb_pkg::wrap_add(head_q, brb_pkg::PTR_W'(1));
						fill_push = fill - brb_pkg::PTR_W'(1);
					end
					if (fill_push < brb_pkg::PTR_W'(brb_pkg::CAPACITY)) begin
						mem_we   = 1'b1;
						tail_n   = brb_pkg::wrap_add(tail_q, brb_pkg::PTR_W'(1));
						push_acc = 1'b1;
					end
				end
			end
			brb_pkg::KIND_DROP: begin
				if (item.drop_all || brb_pkg::PTR_W'(item.drop_count) >= fill)
					head_n = tail_q;
				else
					head_n = brb_pkg::wrap_add(head_q, brb_pkg::PTR_W'(item.drop_count));
			end
			brb_pkg::KIND_READ, brb_pkg::KIND_NONE: begin
			end
			default: begin
			end
		endcase
		fill_new = brb_pkg::fill_of(head_n, tail_n);
		acc      = push_acc || (kind == brb_pkg::KIND_DROP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			burst_rej_q <= 1'b0;
		end else if (cmd.take) begin
			head_q      <= head_n;
			tail_q      <= tail_n;
			burst_rej_q <= rej_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mem_we)
			mem[tail_q] <= item.data_byte;
		if (cmd.rd_issue)
			mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			result_q.accepted   <= acc;
			result_q.read_data  <= 8'd0;
			result_q.read_valid <= 1'b0;
			result_q.fill_count <= 10'(fill_new);
			result_q.free_count <= 10'(brb_pkg::PTR_W'(brb_pkg::CAPACITY) - fill_new);
		end else if (cmd.rd_load) begin
			result_q.accepted   <= 1'b1;
			result_q.read_data  <= mem_rd_q;
			result_q.read_valid <= 1'b1;
			result_q.fill_count <= 10'(fill);
			result_q.free_count <= 10'(brb_pkg::PTR_W'(brb_pkg::CAPACITY) - fill);
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

### hdl/brb_chk.sv
`default_nettype none
module brb_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [brb_pkg::OUT_TDATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (11'(m_tdata[19:10]) + 11'(m_tdata[29:20]) ==
			11'(brb_pkg::CAPACITY)))
		else $error("fill and free counts do not add up to capacity");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[0])
		else $error("read valid without accepted");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> m_tdata[8:1] == 8'd0)
		else $error("read data nonzero without read valid");

	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output word is stalled");

endmodule

bind byte_ring_buffer_unit brb_chk u_brb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_OPS  = 850;

	typedef struct {
		brb_pkg::kind_t kind;
		brb_pkg::item_t fields;
		bit             drain_first;
	} op_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = brb_pkg::KIND_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	byte_ring_buffer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ring model state
	logic [7:0]  ring_mem [0:brb_pkg::SLOTS-1];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	bit          ring_burst_rej = 1'b0;

	op_word_t         word_q [$];
	brb_pkg::result_t pending_results [$];

	int  cycle_count = 0;
	int  in_count = 0;
	int  out_count = 0;
	int  err_count = 0;
	bit  in_took = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;
	op_word_t tx_word;
	brb_pkg::result_t mon_got, mon_want;

	// receiver
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       pat_left = 0;
	logic [7:0] stall_pat = 8'hFF;

	function automatic int unsigned ring_fill();
		if (ring_tail >= ring_head)
			return ring_tail - ring_head;
		return brb_pkg::SLOTS - ring_head + ring_tail;
	endfunction

	function automatic brb_pkg::result_t ring_apply(brb_pkg::kind_t k, brb_pkg::item_t it);
		brb_pkg::result_t r;
		int unsigned      fill;
		r = '0;
		fill = ring_fill();
		case (k)
			brb_pkg::KIND_PUSH: begin
				if (it.burst_start)
					ring_burst_rej = (it.burst_length == 16'd0) ||
						(!it.overwrite_old && it.burst_length > brb_pkg::CAPACITY - fill);
				if (!ring_burst_rej) begin
					// overwrite: oldest byte goes first
					if (fill >= brb_pkg::CAPACITY && it.overwrite_old) begin
						ring_head = (ring_head + 1) % brb_pkg::SLOTS;
						fill--;
					end
					if (fill < brb_pkg::CAPACITY) begin
						ring_mem[ring_tail] = it.data_byte;
						ring_tail = (ring_tail + 1) % brb_pkg::SLOTS;
						r.accepted = 1'b1;
					end
				end
			end
			brb_pkg::KIND_READ: begin
				if (it.read_offset < fill) begin
					r.read_data  = ring_mem[(ring_head + it.read_offset) % brb_pkg::SLOTS];
					r.read_valid = 1'b1;
					r.accepted   = 1'b1;
				end
			end
			brb_pkg::KIND_DROP: begin
				if (it.drop_all || it.drop_count >= fill)
					ring_head = ring_tail;
				else
					ring_head = (ring_head + it.drop_count) % brb_pkg::SLOTS;
				r.accepted = 1'b1;
			end
			default: ;
		endcase
		fill = ring_fill();
		r.fill_count = 10'(fill);
		r.free_count = 10'(brb_pkg::CAPACITY - fill);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s, word %0d: got %0h, want %0h",
			$time, what, out_count, got, want);
		err_count++;
	endtask

	// stimulus builders; fields unused by an op carry random bits, or all ones in q_noop(1)
	function automatic brb_pkg::item_t rand_fields();
		brb_pkg::item_t it;
		it = 47'({$urandom, $urandom});
		return it;
	endfunction

	task automatic q_push(input bit st, input int blen, input bit ow, input int d,
		input bit drain = 1'b0);
		brb_pkg::item_t it;
		it = rand_fields();
		it.burst_start   = st;
		it.burst_length  = 16'(blen);
		it.overwrite_old = ow;
		it.data_byte     = 8'(d);
		word_q.push_back('{kind: brb_pkg::KIND_PUSH, fields: it, drain_first: drain});
	endtask

	task automatic q_read(input int off);
		brb_pkg::item_t it;
		it = rand_fields();
		it.read_offset = 10'(off);
		word_q.push_back('{kind: brb_pkg::KIND_READ, fields: it, drain_first: 1'b0});
	endtask

	task automatic q_drop(input int cnt, input bit all);
		brb_pkg::item_t it;
		it = rand_fields();
		it.drop_count = 10'(cnt);
		it.drop_all   = all;
		word_q.push_back('{kind: brb_pkg::KIND_DROP, fields: it, drain_first: 1'b0});
	endtask

	task automatic q_noop(input bit ones);
		brb_pkg::item_t it;
		it = ones ? '1 : rand_fields();
		word_q.push_back('{kind: brb_pkg::KIND_NONE, fields: it, drain_first: 1'b0});
	endtask

	task automatic q_burst(input int n, input int claimed, input bit ow,
		input bit drain = 1'b0);
		q_push(1'b1, claimed, ow, $urandom_range(0, 255), drain);
		for (int i = 1; i < n; i++)
			q_push(1'b0, $urandom_range(0, 65535), ow, $urandom_range(0, 255));
	endtask

	task automatic build_stimulus();
		int ops;
		int pick;
		int n;
		bit deep_done;
		ops = 0;
		deep_done = 1'b0;

		// directed: empty buffer, burst checks, reads and drops at the edges
		q_read(0);
		q_drop(0, 1'b0);
		q_push(1'b1, 0, 1'b1, 8'h00);       // zero length, rejected even in overwrite
		q_push(1'b0, 5, 1'b0, 8'hFF);       // follows the rejected start
		q_push(1'b1, 65535, 1'b0, 8'hAA);   // does not fit
		q_push(1'b1, 65535, 1'b1, 8'hFF);   // overwrite mode skips the room check
		q_push(1'b0, 0, 1'b0, 8'h00);
		q_push(1'b1, 1022, 1'b0, 8'h5A);    // one more than the room
		q_push(1'b1, 1021, 1'b0, 8'h01);    // exactly the room
		q_read(0);
		q_read(2);
		q_read(3);
		q_read(1023);
		q_noop(1'b1);
		q_noop(1'b0);
		q_drop(1, 1'b0);
		q_drop(0, 1'b1);
		q_push(1'b1, 1, 1'b0, 8'h80);
		q_drop(1023, 1'b0);
		q_push(1'b1, 2, 1'b0, 8'h7F);
		q_push(1'b0, 2, 1'b0, 8'hFE);
		q_drop(2, 1'b0);                     // count equal to fill

		while (ops < RANDOM_OPS) begin
			if (!deep_done && ops >= RANDOM_OPS / 2) begin
				// sender idles until all results are in, then sends one
				// long burst in overwrite mode and probes around it
				deep_done = 1'b1;
				q_burst(400, 400, 1'b1, 1'b1);
				q_read(0);
				q_read(399);
				q_read(1022);
				q_read(1023);
				q_read($urandom_range(1, 398));
				q_push(1'b0, 1, 1'b0, 8'h33);   // follows the accepted burst
				q_push(1'b1, 1, 1'b0, 8'h11);
				q_drop(1022, 1'b0);
				q_read(0);
				ops += 409;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = $urandom_range(1, 24);
				pick = $urandom_range(0, 19);
				q_burst(n, (pick < 17) ? n : (pick < 19) ? $urandom_range(0, 65535) : 0,
					($urandom_range(0, 4) == 0));
				ops += n;
			end else if (pick < 68) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 9);
					q_read((pick < 7) ? $urandom_range(0, 31) :
						(pick < 9) ? $urandom_range(0, 127) : $urandom_range(0, 1023));
				end
				ops += n;
			end else if (pick < 85) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					q_drop($urandom_range(0, 16), 1'b0);
				else if (pick < 8)
					q_drop($urandom_range(0, 1023), 1'b0);
				else
					q_drop($urandom_range(0, 1023), 1'b1);
				ops++;
			end else if (pick < 93) begin
				q_noop(1'b0);
				ops++;
			end else begin
				// stray bytes with no burst start
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					q_push(1'b0, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
						$urandom_range(0, 255));
				ops += n;
			end
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_took) begin
				// word still waiting, hold it
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (word_q.size() == 0 ||
				(word_q[0].drain_first && pending_results.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				tx_word = word_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {1'b0, tx_word.fields};
				s_tuser  <= tx_word.kind;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			in_took = 1'b0;
		end
	end

	// receiver: rotating stall pattern, plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && in_count >= 400) begin
				hold_done = 1'b1;
				hold_left = 150;
				m_tready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_left  = $urandom_range(8, 120);
					stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
				end
				pat_left--;
				m_tready <= stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[7:1]};
			end
		end
	end

	// monitor and acceptance; output side first so a word taken this edge
	// can never be matched against its own result
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 32'd0);
				end else begin
					mon_want = pending_results.pop_front();
					mon_got  = m_tdata[29:0];
					if (mon_got.accepted !== mon_want.accepted)
						report_mismatch("accepted", 32'(mon_got.accepted),
							32'(mon_want.accepted));
					if (mon_got.read_data !== mon_want.read_data)
						report_mismatch("read_data", 32'(mon_got.read_data),
							32'(mon_want.read_data));
					if (mon_got.read_valid !== mon_want.read_valid)
						report_mismatch("read_valid", 32'(mon_got.read_valid),
							32'(mon_want.read_valid));
					if (mon_got.fill_count !== mon_want.fill_count)
						report_mismatch("fill_count", 32'(mon_got.fill_count),
							32'(mon_want.fill_count));
					if (mon_got.free_count !== mon_want.free_count)
						report_mismatch("free_count", 32'(mon_got.free_count),
							32'(mon_want.free_count));
				end
				out_count++;
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(ring_apply(brb_pkg::kind_t'(s_tuser),
					brb_pkg::item_t'(s_tdata[46:0])));
				in_took = 1'b1;
				in_count++;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int drain;
		drain = 0;
		build_stimulus();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		while (word_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 32'(pending_results.size()), 32'd0);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
